/* design/sdtq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdtq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned DL_W    = 32;
  localparam int unsigned HDL_W   = 16;
  localparam int unsigned BATCH_W = 7;

  localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd20;
  localparam logic [BATCH_W-1:0] BATCH_MIN   = 7'd1;
  localparam logic [BATCH_W-1:0] BATCH_MAX   = 7'd64;

  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_EXPIRED  = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SERVE = 1'b1
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [DL_W-1:0]  key;
    logic [HDL_W-1:0] hdl;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/sorted_deadline_timer_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_command, in_deadline, in_handle, in_now_tick
// out     | output    | out_valid/out_stall| out_kind, out_expired_handle, out_last
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (batch limit)
//
// add: the whole cell chain inserts in parallel, result registered next edge
// service: after the accept, one expired timer popped per cycle while out_stall is low
//   (head cell compare); the second cell or the batch limit flags the last pop
// a new transaction is taken only when idle and the output register is free
// reset (synchronous, active low) empties the queue and loads batch limit 20
// out_stall simply holds the output register and pauses popping
module sorted_deadline_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input transactions
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_command,
  input  wire logic [sdtq_pkg::DL_W-1:0]     in_deadline,
  input  wire logic [sdtq_pkg::HDL_W-1:0]    in_handle,
  input  wire logic [sdtq_pkg::DL_W-1:0]     in_now_tick,
  // result transactions
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_kind,
  output logic [sdtq_pkg::HDL_W-1:0]        out_expired_handle,
  output logic                              out_last,
  // batch limit register
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sdtq_pkg::BATCH_W-1:0] cfg_data
);
  import sdtq_pkg::*;

  // per-cell taps of the chain
  logic             c_valid    [QUEUE_DEPTH];
  logic             c_keep     [QUEUE_DEPTH];
  logic [DL_W-1:0]  c_deadline [QUEUE_DEPTH];
  logic [HDL_W-1:0] c_handle   [QUEUE_DEPTH];

  cell_ctl_t ctl;

  state_t state_r, state_nxt;

  logic [BATCH_W-1:0] batch_limit_r;
  logic [BATCH_W-1:0] lim_r, lim_nxt;
  logic [BATCH_W-1:0] cnt_r, cnt_nxt;
  logic [DL_W-1:0]    now_r, now_nxt;

  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [HDL_W-1:0]   out_handle_r, out_handle_nxt;
  logic               out_last_r, out_last_nxt;

  logic in_acc;
  logic out_free;
  logic full;
  logic head_exp;
  logic next_exp;

  // ---------------------------------------------------------------------------
  // chain of cells: cell 0 is the front (earliest deadline)
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             lv, lk, rv;
    logic [DL_W-1:0]  ld, rd;
    logic [HDL_W-1:0] lh, rh;

    if (i == 0) begin : g_left_edge
      // front cell sees an always-kept, always-valid left neighbor
      assign lv = 1'b1;
      assign lk = 1'b1;
      assign ld = ctl.key;
      assign lh = ctl.hdl;
    end else begin : g_left
      assign lv = c_valid[i-1];
      assign lk = c_keep[i-1];
      assign ld = c_deadline[i-1];
      assign lh = c_handle[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_right_edge
      // back cell empties on a pop
      assign rv = 1'b0;
      assign rd = c_deadline[i];
      assign rh = c_handle[i];
    end else begin : g_right
      assign rv = c_valid[i+1];
      assign rd = c_deadline[i+1];
      assign rh = c_handle[i+1];
    end

    sdtq_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .left_valid     (lv),
      .left_keep      (lk),
      .left_deadline  (ld),
      .left_handle    (lh),
      .right_valid    (rv),
      .right_deadline (rd),
      .right_handle   (rh),
      .valid          (c_valid[i]),
      .keep           (c_keep[i]),
      .deadline       (c_deadline[i]),
      .handle         (c_handle[i])
    );
  end

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // queue is full when the back cell holds an entry
  assign full = c_valid[QUEUE_DEPTH-1];

  // head expiry and the one behind it, used to mark the last of a batch
  assign head_exp = c_valid[0] && (c_deadline[0] <= now_r);
  assign next_exp = c_valid[1] && (c_deadline[1] <= now_r);

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    lim_nxt        = lim_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    ctl.ins        = 1'b0;
    ctl.pop        = 1'b0;
    ctl.key        = in_deadline;
    ctl.hdl        = in_handle;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_ADD) begin
            ctl.ins        = !full;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = full ? KIND_ADD_FULL : KIND_ADD_OK;
            out_handle_nxt = '0;
            out_last_nxt   = 1'b1;
          end else begin
            // clamp the batch limit into 1..64
            if (batch_limit_r == '0) begin
              lim_nxt = BATCH_MIN;
            end else if (batch_limit_r > BATCH_MAX) begin
              lim_nxt = BATCH_MAX;
            end else begin
              lim_nxt = batch_limit_r;
            end
            cnt_nxt   = '0;
            now_nxt   = in_now_tick;
            state_nxt = ST_SERVE;
          end
        end
      end
      ST_SERVE: begin
        if (out_free) begin
          if (head_exp) begin
            ctl.pop        = 1'b1;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_EXPIRED;
            out_handle_nxt = c_handle[0];
            out_last_nxt   = ((cnt_r + 7'd1) == lim_r) || !next_exp;
            cnt_nxt        = cnt_r + 7'd1;
            if (out_last_nxt) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            // nothing expired at all
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      batch_limit_r <= BATCH_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        batch_limit_r <= cfg_data;
      end
    end
    lim_r        <= lim_nxt;
    cnt_r        <= cnt_nxt;
    now_r        <= now_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_expired_handle = out_handle_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

/* design/sdtq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdtq_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sdtq_pkg::cell_ctl_t       ctl,
  input  wire logic                      left_valid,
  input  wire logic                      left_keep,
  input  wire logic [sdtq_pkg::DL_W-1:0]  left_deadline,
  input  wire logic [sdtq_pkg::HDL_W-1:0] left_handle,
  input  wire logic                      right_valid,
  input  wire logic [sdtq_pkg::DL_W-1:0]  right_deadline,
  input  wire logic [sdtq_pkg::HDL_W-1:0] right_handle,
  output logic                           valid,
  output logic                           keep,
  output logic [sdtq_pkg::DL_W-1:0]       deadline,
  output logic [sdtq_pkg::HDL_W-1:0]      handle
);
  import sdtq_pkg::*;

  logic             valid_r, valid_nxt;
  logic [DL_W-1:0]  deadline_r, deadline_nxt;
  logic [HDL_W-1:0] handle_r, handle_nxt;

  // entry stays put on insert when it sorts at or before the new key
  assign keep = valid_r && (deadline_r <= ctl.key);

  always_comb begin
    valid_nxt    = valid_r;
    deadline_nxt = deadline_r;
    handle_nxt   = handle_r;
    if (ctl.ins && !keep) begin
      valid_nxt = valid_r | left_valid;
      if (left_keep) begin
        deadline_nxt = ctl.key;
        handle_nxt   = ctl.hdl;
      end else begin
        deadline_nxt = left_deadline;
        handle_nxt   = left_handle;
      end
    end else if (ctl.pop) begin
      valid_nxt    = right_valid;
      deadline_nxt = right_deadline;
      handle_nxt   = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    deadline_r <= deadline_nxt;
    handle_r   <= handle_nxt;
  end

  assign valid    = valid_r;
  assign deadline = deadline_r;
  assign handle   = handle_r;

endmodule

`default_nettype wire

/* design/sdtq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdtq_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         in_command,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [1:0]                   out_kind,
  input wire logic [sdtq_pkg::HDL_W-1:0]   out_expired_handle,
  input wire logic                         out_last
);
  import sdtq_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_expired_handle) && $stable(out_last))
    else $error("stalled result changed");

  // an add transaction answers on the next edge with an add result
  a_add_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_ADD) |=>
      out_valid && ((out_kind == KIND_ADD_OK) || (out_kind == KIND_ADD_FULL)))
    else $error("add transaction without add result");

  // add results are single and carry no handle
  a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_EXPIRED) |-> out_last && (out_expired_handle == '0))
    else $error("bad add result fields");

  // no input taken while a result waits stalled
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_command         (in_command),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_expired_handle (out_expired_handle),
  .out_last           (out_last)
);

`default_nettype wire

/* verif/tb_sorted_deadline_timer_queue.sv */
`timescale 1ns / 1ps

module tb_sorted_deadline_timer_queue;
  import sdtq_pkg::*;

  // sizes of the run
  localparam int unsigned DEPTH           = QUEUE_DEPTH_DEF;
  localparam int unsigned MAX_POPS        = 64;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 49;

  // one result transaction as the checker sees it
  typedef struct packed {
    kind_t            kind;
    logic [HDL_W-1:0] hdl;
    logic             last;
  } timer_result_t;

  // one row of the directed table; known rows carry their result typed in
  typedef struct {
    logic             cmd;
    logic [DL_W-1:0]  dl;
    logic [HDL_W-1:0] hd;
    logic [DL_W-1:0]  now;
    bit               known;
    int               known_n;
    kind_t            known_kind;
    logic [HDL_W-1:0] known_hdl;
  } stim_row_t;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic                in_command  = CMD_ADD;
  logic [DL_W-1:0]     in_deadline = '0;
  logic [HDL_W-1:0]    in_handle   = '0;
  logic [DL_W-1:0]     in_now_tick = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [1:0]          out_kind;
  logic [HDL_W-1:0]    out_expired_handle;
  logic                out_last;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [BATCH_W-1:0]  cfg_data    = '0;

  // shadow copy of the timer queue and the batch limit register
  logic [DL_W-1:0]     mdl_deadline [DEPTH];
  logic [HDL_W-1:0]    mdl_handle   [DEPTH];
  int unsigned         mdl_count    = 0;
  logic [BATCH_W-1:0]  mdl_batch    = BATCH_RESET;

  // results still owed by the block, oldest first
  timer_result_t       awaited_results [$];

  int unsigned         mismatch_count = 0;
  int unsigned         run_cycles     = 0;
  int unsigned         send_idle      = 20;
  int unsigned         recv_idle      = 79;
  int unsigned         hold_token     = 0;
  int unsigned         hold_seen      = 0;
  int unsigned         hold_left      = 0;

  sorted_deadline_timer_queue DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_deadline        (in_deadline),
    .in_handle          (in_handle),
    .in_now_tick        (in_now_tick),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_expired_handle (out_expired_handle),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs or drops results
  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", run_cycles, what);
    mismatch_count++;
  endtask

  // applies one command to the shadow queue; when record is set the
  // results it causes are queued for the checker
  function automatic void model_timer_command(input logic cmd, input logic [DL_W-1:0] dl,
      input logic [HDL_W-1:0] hd, input logic [DL_W-1:0] now, input bit record);
    int unsigned   pos;
    int unsigned   lim;
    int unsigned   n;
    int unsigned   i;
    timer_result_t r;
    timer_result_t popped [$];
    if (cmd == CMD_ADD) begin
      r.hdl  = '0;
      r.last = 1'b1;
      if (mdl_count >= DEPTH) begin
        // queue full, the new timer is lost
        r.kind = KIND_ADD_FULL;
      end else begin
        // land behind every timer with an equal or earlier deadline
        pos = 0;
        while (pos < mdl_count && mdl_deadline[pos] <= dl) pos++;
        for (i = mdl_count; i > pos; i--) begin
          mdl_deadline[i] = mdl_deadline[i-1];
          mdl_handle[i]   = mdl_handle[i-1];
        end
        mdl_deadline[pos] = dl;
        mdl_handle[pos]   = hd;
        mdl_count++;
        r.kind = KIND_ADD_OK;
      end
      if (record) awaited_results.push_back(r);
    end else begin
      // zero acts as one, anything above the ceiling is clipped
      if (mdl_batch == 0) lim = 1;
      else if (mdl_batch > MAX_POPS) lim = MAX_POPS;
      else lim = mdl_batch;
      n = 0;
      while (n < lim && n < mdl_count && mdl_deadline[n] <= now) begin
        r.kind = KIND_EXPIRED;
        r.hdl  = mdl_handle[n];
        r.last = 1'b0;
        popped.push_back(r);
        n++;
      end
      if (n != 0) begin
        popped[n-1].last = 1'b1;
        for (i = n; i < mdl_count; i++) begin
          mdl_deadline[i-n] = mdl_deadline[i];
          mdl_handle[i-n]   = mdl_handle[i];
        end
        mdl_count -= n;
        if (record) begin
          foreach (popped[j]) awaited_results.push_back(popped[j]);
        end
      end
    end
  endfunction

  function automatic stim_row_t stim_row(input logic cmd, input logic [DL_W-1:0] dl,
      input logic [HDL_W-1:0] hd, input logic [DL_W-1:0] now, input bit known,
      input int known_n, input kind_t known_kind, input logic [HDL_W-1:0] known_hdl);
    stim_row_t r;
    r.cmd        = cmd;
    r.dl         = dl;
    r.hd         = hd;
    r.now        = now;
    r.known      = known;
    r.known_n    = known_n;
    r.known_kind = known_kind;
    r.known_hdl  = known_hdl;
    return r;
  endfunction

  // offers one transaction, possibly after a random gap, and returns at the
  // edge that takes it; valid stays high so the caller decides the next step
  task automatic send_item(input logic cmd, input logic [DL_W-1:0] dl,
      input logic [HDL_W-1:0] hd, input logic [DL_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_deadline <= dl;
    in_handle   <= hd;
    in_now_tick <= now;
    do @(posedge clk); while (in_stall);
  endtask

  // sender stops until every owed result has come back
  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // batch limit only changes while the block is idle; a service that pops
  // nothing leaves no trace, so give it time to finish first
  task automatic write_batch(input logic [BATCH_W-1:0] value);
    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_batch = value;
  endtask

  // result side: check every accepted transaction, then pick the next stall
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d handle %h last %b",
                                  out_kind, out_expired_handle, out_last));
      end else begin
        want = awaited_results.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_expired_handle !== want.hdl)
          report_mismatch($sformatf("handle %h, want %h", out_expired_handle, want.hdl));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_last, want.last));
      end
    end
    // a long hold-off lets the block back up into its input
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  initial begin : stimulus
    stim_row_t          rows [$];
    timer_result_t      typed;
    logic               cmd;
    logic [DL_W-1:0]    dl;
    logic [HDL_W-1:0]   hd;
    logic [DL_W-1:0]    now;
    logic [DL_W-1:0]    tick_base;
    logic [BATCH_W-1:0] new_batch;
    int unsigned        pick;
    int unsigned        add_odds;

    // directed table, batch limit still at its reset value
    // service on an empty queue gives nothing
    rows.push_back(stim_row(CMD_SERVICE, '0, '0, 32'hFFFF_FFFF, 1, 0, KIND_ADD_OK, '0));
    rows.push_back(stim_row(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, '0, 1, 1, KIND_ADD_OK, '0));
    rows.push_back(stim_row(CMD_ADD, 32'h0, 16'h0F0F, 32'hFFFF_FFFF, 1, 1, KIND_ADD_OK, '0));
    // equal deadlines must leave in arrival order
    rows.push_back(stim_row(CMD_ADD, 32'd100, 16'h1234, '0, 1, 1, KIND_ADD_OK, '0));
    rows.push_back(stim_row(CMD_ADD, 32'd100, 16'h5678, '0, 1, 1, KIND_ADD_OK, '0));
    // tick zero expires only the deadline-zero timer
    rows.push_back(stim_row(CMD_SERVICE, '0, '0, 32'd0, 1, 1, KIND_EXPIRED, 16'h0F0F));
    // one tick early, nothing expired
    rows.push_back(stim_row(CMD_SERVICE, '0, '0, 32'd99, 1, 0, KIND_ADD_OK, '0));
    rows.push_back(stim_row(CMD_SERVICE, '0, '0, 32'd100, 0, 0, KIND_ADD_OK, '0));
    // fill up, falling deadlines go to the front but a tie sorts behind
    for (int unsigned i = 0; i < DEPTH - 1; i++) begin
      dl = (i % 4 == 3) ? 32'(500 - 30 * (i - 1)) : 32'(500 - 30 * i);
      rows.push_back(stim_row(CMD_ADD, dl, 16'(16'hA000 + i), '0, 1, 1, KIND_ADD_OK, '0));
    end
    // full queue drops the timer
    rows.push_back(stim_row(CMD_ADD, 32'd7, 16'hBEEF, '0, 1, 1, KIND_ADD_FULL, '0));
    // everything expires at the top tick
    rows.push_back(stim_row(CMD_SERVICE, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 0, 0,
                            KIND_ADD_OK, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[j]) begin
      send_item(rows[j].cmd, rows[j].dl, rows[j].hd, rows[j].now);
      if (rows[j].known) begin
        model_timer_command(rows[j].cmd, rows[j].dl, rows[j].hd, rows[j].now, 0);
        if (rows[j].known_n != 0) begin
          typed.kind = rows[j].known_kind;
          typed.hdl  = rows[j].known_hdl;
          typed.last = 1'b1;
          awaited_results.push_back(typed);
        end
      end else begin
        model_timer_command(rows[j].cmd, rows[j].dl, rows[j].hd, rows[j].now, 1);
      end
    end

    // random phases, each under its own batch limit, in three idling patterns
    tick_base = $urandom;
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       new_batch = BATCH_MIN;
        1:       new_batch = BATCH_MAX;
        2:       new_batch = 7'd0;
        3:       new_batch = 7'h7F;
        4:       new_batch = 7'd2;
        5:       new_batch = 7'($urandom_range(3, 63));
        6:       new_batch = 7'(DEPTH);
        default: new_batch = BATCH_RESET;
      endcase
      if (ph < 3) begin
        send_idle = 20;
        recv_idle = 79;
      end else if (ph < 6) begin
        send_idle = 79;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_batch(new_batch);

      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 1 && k == 10) hold_token <= hold_token + 1;
        if (ph == 4 && k == 25) drain_wait();

        pick = $urandom_range(0, 99);
        hd   = 16'($urandom_range(0, 16'hFFFF));
        // keep the queue near full so drops and long batches show up
        add_odds = (mdl_count < DEPTH) ? 62 : 30;
        if (pick < 8) begin
          // noise: any field value at all
          cmd = 1'($urandom_range(0, 1));
          dl  = $urandom;
          now = $urandom;
        end else if (pick < add_odds) begin
          cmd = CMD_ADD;
          now = $urandom;
          if (mdl_count != 0 && $urandom_range(0, 4) == 0)
            dl = mdl_deadline[$urandom_range(0, mdl_count - 1)];
          else
            dl = tick_base + $urandom_range(0, 300);
        end else begin
          cmd = CMD_SERVICE;
          dl  = $urandom;
          case ($urandom_range(0, 9))
            0:       now = (mdl_count != 0) ? mdl_deadline[0] - 1 : $urandom;
            1, 2:    now = tick_base + $urandom_range(0, 400);
            default: now = (mdl_count != 0) ? mdl_deadline[$urandom_range(0, mdl_count - 1)]
                                            : tick_base;
          endcase
          tick_base = tick_base + $urandom_range(0, 60);
        end
        send_item(cmd, dl, hd, now);
        model_timer_command(cmd, dl, hd, now, 1);
      end
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
